FILE: sv/lpfc_pkg.sv
// Shared types, constants and Q1.15 arithmetic helpers for the lowpass feedback comb filter.
// No dependencies; imported by lpfc_ram users and the top level.
package lpfc_pkg;

   localparam int DATA_W     = 16;
   localparam int BACK_W     = 12;
   localparam int LEN_CFG_W  = 13;
   localparam int CSR_IDX_W  = 8;
   localparam int REQ_DATA_W = 32;   // sample_in + samples_back, padded to bytes
   localparam int RSP_DATA_W = 32;   // sample_out + tap_sample
   localparam int PROD_W     = 2 * DATA_W;
   localparam int RND_W      = DATA_W + 1;
   localparam int SUM_W      = DATA_W + 2;
   localparam int STEPS_PER_CYCLE = 4;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_COMB_GAIN   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LP_IN_GAIN  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LP_FB_GAIN  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_LEN   = 8'd3;

   localparam logic signed [DATA_W-1:0] COMB_GAIN_RST  = 16'sd27525;
   localparam logic signed [DATA_W-1:0] LP_IN_GAIN_RST = 16'sd26214;
   localparam logic signed [DATA_W-1:0] LP_FB_GAIN_RST = 16'sd6554;
   localparam logic [LEN_CFG_W-1:0]     DELAY_LEN_RST  = 13'd4096;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MULA,
      ST_LOWPASS,
      ST_MULG,
      ST_WRITE,
      ST_TAPRD,
      ST_OUT
   } lpfc_state_type;

   // round a Q2.30 product half up to Q1.15 (may reach +1.0)
   function automatic logic signed [RND_W-1:0] q15_round(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] biased;
      biased = p + 32'sd16384;
      return biased[PROD_W-1:DATA_W-1];
   endfunction

   function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: sv/lpfc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module lpfc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/lowpass_feedback_comb_filter.sv
// Top level of the lowpass feedback comb filter: FSM, Q1.15 datapath and delay memory.
// Depends on lpfc_pkg and lpfc_ram.
//
// Usage:
//   req_* carries one input item: sample_in and samples_back. rsp_* returns one result
//   item per input: the sample delayed by delay_length and a tap read after the write.
//   csr_* writes the gain and length registers; it is always ready and must only be
//   used while the block is idle.
// Timing:
//   An item passes the states read, multiply, lowpass, gain multiply, write, tap read and
//   output; the next item is accepted the cycle after the result is loaded into the output
//   register. The pace is set by the single delay memory port pair (read, write, tap read)
//   and the chained multiplies through the lowpass and the feedback gain; the tap modulo
//   runs three steps of four remainder bits alongside the memory read and the lowpass.
// Reset:
//   Clears the pointer, the lowpass state and the fill count; entries at or above the
//   fill count read as zero, so no clearing pass is needed. Gains and the delay length return to defaults.
// Stall:
//   A result waits in the output register; a finished item holds in the last state
//   until that register is free. No item is dropped.
module lowpass_feedback_comb_filter #(
   parameter int MAX_DELAY = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [15:0] sample_in, [27:16] samples_back, [31:28] zero
   input  logic [lpfc_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] sample_out, [31:16] tap_sample
   output logic [lpfc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lpfc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lpfc_pkg::DATA_W-1:0]          csr_data
);
   import lpfc_pkg::*;

   localparam int AW   = $clog2(MAX_DELAY);
   localparam int LW   = $clog2(MAX_DELAY + 1);
   localparam int CMPW = (LW > LEN_CFG_W) ? LW : LEN_CFG_W;

   lpfc_state_type state_ff, state_in;

   logic signed [DATA_W-1:0] comb_gain_ff, lp_in_gain_ff, lp_fb_gain_ff;
   logic [LEN_CFG_W-1:0]     delay_len_ff;
   logic [LW-1:0]            len_act;

   logic [AW-1:0]            wp_ff, wp_eff_ff, tap_addr_ff;
   logic [LW-1:0]            hw_ff;
   logic signed [DATA_W-1:0] lp_ff, x_ff, delayed_ff;
   logic [BACK_W-1:0]        rem_ff, back_sh_ff, rem_c, bits_c;
   logic [BACK_W:0]          trial;
   logic signed [PROD_W-1:0] prod_a_ff, prod_b_ff;
   logic                     rd_hit_ff, tap_hit_ff;
   logic                     rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]    rsp_tdata_ff;

   logic                     ram_we, ram_re, load_out, accept;
   logic [AW-1:0]            ram_raddr;
   logic [DATA_W-1:0]        ram_rdata;
   logic signed [DATA_W-1:0] delayed_c, written_c, tap_c;
   logic [AW-1:0]            wp_eff_c;
   logic [LW-1:0]            wp_inc;
   logic [CMPW-1:0]          newest_x, back_x, tap_x;

   // active length: zero acts as one, clamp to the memory depth
   always_comb begin
      if (delay_len_ff == '0) begin
         len_act = LW'(1);
      end else if (CMPW'(delay_len_ff) > CMPW'(MAX_DELAY)) begin
         len_act = LW'(MAX_DELAY);
      end else begin
         len_act = LW'(delay_len_ff);
      end
   end

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         comb_gain_ff  <= COMB_GAIN_RST;
         lp_in_gain_ff <= LP_IN_GAIN_RST;
         lp_fb_gain_ff <= LP_FB_GAIN_RST;
         delay_len_ff  <= DELAY_LEN_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COMB_GAIN:  comb_gain_ff  <= csr_data;
            CSR_LP_IN_GAIN: lp_in_gain_ff <= csr_data;
            CSR_LP_FB_GAIN: lp_fb_gain_ff <= csr_data;
            CSR_DELAY_LEN:  delay_len_ff  <= csr_data[LEN_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_tvalid) state_in = ST_READ;
         ST_READ:    state_in = ST_MULA;
         ST_MULA:    state_in = ST_LOWPASS;
         ST_LOWPASS: state_in = ST_MULG;
         ST_MULG:    state_in = ST_WRITE;
         ST_WRITE:   state_in = ST_TAPRD;
         ST_TAPRD:   state_in = ST_OUT;
         ST_OUT:     if (!rsp_tvalid_ff || rsp_tready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = 1'b0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      ram_raddr  = wp_eff_ff;
      load_out   = 1'b0;
      case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_READ:  ram_re = 1'b1;
         ST_WRITE: ram_we = 1'b1;
         ST_TAPRD: begin
            ram_re    = 1'b1;
            ram_raddr = tap_addr_ff;
         end
         ST_OUT:   load_out = !rsp_tvalid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   lpfc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_DELAY)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_eff_ff),
      .wr_data (written_c),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // restart the pointer if the length shrank below it
   assign wp_eff_c = (CMPW'(wp_ff) >= CMPW'(len_act)) ? '0 : wp_ff;
   assign wp_inc   = LW'(wp_eff_ff) + LW'(1);

   // tap distance modulo length: restoring remainder, four bits per cycle
   always_comb begin
      rem_c  = rem_ff;
      bits_c = back_sh_ff;
      trial  = '0;
      for (int i = 0; i < STEPS_PER_CYCLE; i++) begin
         trial  = {rem_c, bits_c[BACK_W-1]};
         bits_c = bits_c << 1;
         if (CMPW'(trial) >= CMPW'(len_act)) begin
            rem_c = BACK_W'(CMPW'(trial) - CMPW'(len_act));
         end else begin
            rem_c = trial[BACK_W-1:0];
         end
      end
   end

   // tap address, wrapping within the active length
   assign newest_x = CMPW'(wp_eff_ff);
   assign back_x   = CMPW'(rem_ff);
   assign tap_x    = (newest_x >= back_x) ? (newest_x - back_x)
                                          : (newest_x + CMPW'(len_act) - back_x);

   // entries at or above the fill count were never written and read as zero
   assign delayed_c = rd_hit_ff ? ram_rdata : '0;
   assign tap_c     = tap_hit_ff ? ram_rdata : '0;
   assign written_c = sat16(SUM_W'(x_ff) + SUM_W'(q15_round(prod_a_ff)));

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         hw_ff <= '0;
         lp_ff <= '0;
      end else begin
         if (state_ff == ST_LOWPASS) begin
            lp_ff <= sat16(SUM_W'(q15_round(prod_a_ff)) + SUM_W'(q15_round(prod_b_ff)));
         end
         if (state_ff == ST_WRITE) begin
            wp_ff <= (wp_inc >= len_act) ? '0 : AW'(wp_inc);
            if (LW'(wp_eff_ff) == hw_ff) begin
               hw_ff <= hw_ff + LW'(1);
            end
         end
      end
   end

   // item datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff       <= req_tdata[DATA_W-1:0];
         back_sh_ff <= req_tdata[DATA_W +: BACK_W];
         rem_ff     <= '0;
         wp_eff_ff  <= wp_eff_c;
      end
      case (state_ff)
         ST_READ: begin
            rd_hit_ff  <= LW'(wp_eff_ff) < hw_ff;
            rem_ff     <= rem_c;
            back_sh_ff <= bits_c;
         end
         ST_MULA: begin
            delayed_ff <= delayed_c;
            prod_a_ff  <= lp_in_gain_ff * delayed_c;
            prod_b_ff  <= lp_fb_gain_ff * lp_ff;
            rem_ff     <= rem_c;
            back_sh_ff <= bits_c;
         end
         ST_LOWPASS: begin
            rem_ff     <= rem_c;
            back_sh_ff <= bits_c;
         end
         ST_MULG:  prod_a_ff <= comb_gain_ff * lp_ff;
         ST_WRITE: tap_addr_ff <= AW'(tap_x);
         ST_TAPRD: tap_hit_ff <= LW'(tap_addr_ff) < hw_ff;
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_tdata_ff <= {tap_c, delayed_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // the written prefix of the memory always covers the pointer
   a_fill_covers_pointer: assert property (@(posedge clock) disable iff (reset)
      (LW'(wp_ff) <= hw_ff) && (hw_ff <= LW'(MAX_DELAY)))
      else $error("fill count out of step with write pointer");

   a_write_in_length: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (LW'(wp_eff_ff) < len_act))
      else $error("delay write outside active length");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_tvalid_ff && !rsp_tready) |=> (state_ff == ST_OUT))
      else $error("finished item left before output register was free");

endmodule

FILE: dv/lowpass_feedback_comb_filter_tb.sv
// Self-checking bench for lowpass_feedback_comb_filter: a Q1.15 predictor of the
// delay line and feedback lowpass, scoreboarded against every result item.
// Depends on lpfc_pkg and the RTL under sv/.
module tb;
   import lpfc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH = 4096;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNMAPPED = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_UNMAPPED  = 8'd255;

   typedef struct packed {
      logic signed [DATA_W-1:0] tap_sample;
      logic signed [DATA_W-1:0] sample_out;
   } comb_result_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [DATA_W-1:0]      csr_data;

   // predictor state
   logic signed [DATA_W-1:0] line_mem [0:LINE_DEPTH-1];
   int unsigned              line_wp;
   logic signed [DATA_W-1:0] lp_state;
   logic signed [DATA_W-1:0] gain_g, gain_a0, gain_b0;
   logic [LEN_CFG_W-1:0]     len_cfg;

   comb_result_type pending_outputs[$];
   int              fail_count   = 0;
   bit              req_idle_on  = 1'b1;
   bit              rsp_idle_on  = 1'b1;
   int              hold_request = 0;

   lowpass_feedback_comb_filter #(.MAX_DELAY(LINE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint q15_mul(input logic signed [DATA_W-1:0] a,
                                      input logic signed [DATA_W-1:0] b);
      longint p;
      p = longint'(a) * longint'(b) + 64'sd16384;
      return p >>> 15;
   endfunction

   function automatic logic signed [DATA_W-1:0] clip16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   function automatic void clear_filter_state();
      for (int i = 0; i < LINE_DEPTH; i++) line_mem[i] = '0;
      line_wp  = 0;
      lp_state = '0;
      gain_g   = COMB_GAIN_RST;
      gain_a0  = LP_IN_GAIN_RST;
      gain_b0  = LP_FB_GAIN_RST;
      len_cfg  = DELAY_LEN_RST;
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [DATA_W-1:0] val);
      case (idx)
         CSR_COMB_GAIN:  gain_g  = val;
         CSR_LP_IN_GAIN: gain_a0 = val;
         CSR_LP_FB_GAIN: gain_b0 = val;
         CSR_DELAY_LEN:  len_cfg = val[LEN_CFG_W-1:0];
         default: ;
      endcase
   endfunction

   // advance the delay line by one sample and return the result it produces
   function automatic comb_result_type comb_advance(input logic signed [DATA_W-1:0] smp,
                                                    input logic [BACK_W-1:0] back);
      int unsigned len, tap_back, wp;
      logic signed [DATA_W-1:0] delayed;
      comb_result_type r;
      if (len_cfg == 0) len = 1;
      else if (len_cfg > LINE_DEPTH) len = LINE_DEPTH;
      else len = len_cfg;
      tap_back = back % len;
      wp = (line_wp >= len) ? 0 : line_wp;
      delayed = line_mem[wp];
      lp_state = clip16(q15_mul(gain_a0, delayed) + q15_mul(gain_b0, lp_state));
      line_mem[wp] = clip16(longint'(smp) + q15_mul(gain_g, lp_state));
      line_wp = (wp + 1 >= len) ? 0 : wp + 1;
      r.sample_out = delayed;
      r.tap_sample = line_mem[(wp + len - tap_back) % len];
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_sample(input logic signed [DATA_W-1:0] smp,
                              input logic [BACK_W-1:0] back);
      @(negedge clock);
      if (req_idle_on && $urandom_range(0, 99) < 20) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_tdata  = {4'b0, back, smp};
      req_tvalid = 1'b1;
      forever begin
         @(posedge clock);
         if (req_tready === 1'b1) break;
      end
      pending_outputs.push_back(comb_advance(smp, back));
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      forever begin
         @(posedge clock);
         if (csr_ready === 1'b1) break;
      end
      apply_csr(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // drop valid and hold until every expected item is back
   task automatic drain_outputs();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
   endtask

   // hold off the result side in bursts; a long hold-off is taken on request
   initial begin : rsp_ready_drive
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            rsp_tready = 1'b0;
            repeat (hold_request) @(negedge clock);
            hold_request = 0;
         end else if (rsp_idle_on && $urandom_range(0, 99) < 20) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      comb_result_type want, got;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got = rsp_tdata;
         if (pending_outputs.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: result item with nothing pending: %h", $time, rsp_tdata);
         end else begin
            want = pending_outputs.pop_front();
            if (got.sample_out !== want.sample_out || got.tap_sample !== want.tap_sample) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: mismatch sample_out exp %0d got %0d, tap_sample exp %0d got %0d",
                           $time, $signed(want.sample_out), $signed(got.sample_out),
                           $signed(want.tap_sample), $signed(got.tap_sample));
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic logic [DATA_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [BACK_W-1:0] pick_back();
      if ($urandom_range(0, 3) == 0) return 12'($urandom());
      return 12'($urandom_range(0, 15));
   endfunction

   function automatic logic [DATA_W-1:0] pick_gain();
      int mag;
      mag = $urandom_range(0, 26000);
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2, 3: return 16'($urandom());
         default: return ($urandom_range(0, 1) != 0) ? 16'(-mag) : 16'(mag);
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_length();
      case ($urandom_range(0, 11))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'd4096;
         3: return 16'($urandom());
         4, 5: return 16'($urandom_range(2, 300));
         default: return 16'($urandom_range(1, 24));
      endcase
   endfunction

   task automatic load_random_settings();
      write_csr(CSR_COMB_GAIN, pick_gain());
      write_csr(CSR_LP_IN_GAIN, pick_gain());
      write_csr(CSR_LP_FB_GAIN, pick_gain());
      write_csr(CSR_DELAY_LEN, pick_length());
      if ($urandom_range(0, 3) == 0)
         write_csr(8'($urandom_range(CSR_FIRST_UNMAPPED, CSR_LAST_UNMAPPED)), 16'($urandom()));
   endtask

   // full-scale samples and both tap extremes at the reset settings
   task automatic test_reset_state();
      send_sample(16'sh7fff, 12'd0);
      send_sample(16'sh8000, 12'hfff);
      send_sample(16'sh0000, 12'd1);
      send_sample(16'shffff, 12'd2048);
   endtask

   task automatic test_edge_cases();
      // saturating gains on a three-sample line
      drain_outputs();
      write_csr(CSR_DELAY_LEN, 16'd3);
      write_csr(CSR_COMB_GAIN, 16'h7fff);
      write_csr(CSR_LP_IN_GAIN, 16'h8000);
      write_csr(CSR_LP_FB_GAIN, 16'h8000);
      send_sample(16'sh7fff, 12'd0);
      send_sample(16'sh7fff, 12'd1);
      send_sample(16'sh7fff, 12'd2);
      send_sample(16'sh8000, 12'hfff);
      send_sample(16'sh8000, 12'd5);
      send_sample(16'sh7fff, 12'd3);
      // a zero length behaves as one
      drain_outputs();
      write_csr(CSR_DELAY_LEN, 16'd0);
      send_sample(16'sd100, 12'd0);
      send_sample(16'sh8000, 12'hfff);
      // shrink the line below the write pointer
      drain_outputs();
      write_csr(CSR_DELAY_LEN, 16'd10);
      repeat (5) send_sample(pick_sample(), pick_back());
      drain_outputs();
      write_csr(CSR_DELAY_LEN, 16'd2);
      repeat (3) send_sample(pick_sample(), pick_back());
      // length beyond the memory depth; unmapped indexes must leave settings alone
      drain_outputs();
      write_csr(CSR_DELAY_LEN, 16'hffff);
      write_csr(CSR_COMB_GAIN, 16'h8000);
      write_csr(CSR_LP_IN_GAIN, 16'h7fff);
      write_csr(CSR_LP_FB_GAIN, 16'h7fff);
      write_csr(CSR_FIRST_UNMAPPED, 16'h1234);
      write_csr(CSR_LAST_UNMAPPED, 16'hffff);
      send_sample(16'sh7fff, 12'hfff);
      send_sample(16'sh8000, 12'd0);
      send_sample(pick_sample(), pick_back());
   endtask

   task automatic test_random_settings(input int phases, input int items_per_phase);
      for (int p = 0; p < phases; p++) begin
         drain_outputs();
         load_random_settings();
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         repeat (items_per_phase) send_sample(pick_sample(), pick_back());
      end
   endtask

   // stall the result side long enough that the block backs up into its input
   task automatic test_backpressure();
      drain_outputs();
      req_idle_on  = 1'b0;
      rsp_idle_on  = 1'b1;
      hold_request = 250;
      repeat (40) send_sample(pick_sample(), pick_back());
   endtask

   task automatic test_sender_pause();
      req_idle_on = 1'b1;
      repeat (20) send_sample(pick_sample(), pick_back());
      drain_outputs();
      repeat (20) send_sample(pick_sample(), pick_back());
   endtask

   task automatic test_full_rate();
      drain_outputs();
      load_random_settings();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (150) send_sample(pick_sample(), pick_back());
   endtask

   initial begin : main_sequence
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      clear_filter_state();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_edge_cases();
      test_random_settings(8, 120);
      test_backpressure();
      test_sender_pause();
      test_full_rate();

      drain_outputs();
      repeat (16) @(posedge clock);
      if (pending_outputs.size() != 0) begin
         fail_count++;
         $display("%0d expected result items never arrived", pending_outputs.size());
      end
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : run_limit
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

FILE: lowpass_feedback_comb_filter.f
sv/lpfc_pkg.sv
sv/lpfc_ram.sv
sv/lowpass_feedback_comb_filter.sv
dv/lowpass_feedback_comb_filter_tb.sv
